>>> rtl/assert_macros.svh
// shared assertion macros, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ctc_pkg.sv
`timescale 1ns / 1ps
package ctc_pkg;
    localparam int CW       = 32;          // coordinate width
    localparam int OFS_W    = CW + 1;      // coordinate difference
    localparam int NF       = 14;          // normal fraction bits
    localparam int NW       = 16;          // normal width
    localparam int MW       = 31;          // normalized magnitude
    localparam int SQ_W     = 2 * MW + 1;  // sum of squares
    localparam int LEN_W    = 32;          // edge length root
    localparam int NUM_W    = 47;          // divider numerator
    localparam int Q_W      = 15;          // divider quotient
    localparam int PC_W     = OFS_W + NW;
    localparam int PM_W     = CW + NW;
    localparam int DS_W     = PC_W + 1;
    localparam int DIST_W   = 36;
    localparam int SQRT_STAGES = LEN_W;
    localparam int DIV_STAGES  = Q_W;
    localparam int EDGE_LAT = 5 + SQRT_STAGES + 1 + DIV_STAGES + 4;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    localparam logic signed [DIST_W-1:0] SAT_MAX =
        {{(DIST_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] SAT_MIN =
        {{(DIST_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [NW-1:0]     nx;
        logic signed [NW-1:0]     ny;
        logic signed [DIST_W-1:0] sdist;
        logic                     degen;
        logic                     yield;   // dot(move, normal) <= 0
    } t_edge_res;
endpackage

>>> rtl/ctc_in_if.sv
`timescale 1ns / 1ps
interface ctc_in_if import ctc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] vertex_a_x;
    logic signed [CW-1:0] vertex_a_y;
    logic signed [CW-1:0] vertex_b_x;
    logic signed [CW-1:0] vertex_b_y;
    logic signed [CW-1:0] vertex_c_x;
    logic signed [CW-1:0] vertex_c_y;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [CW-2:0]        radius;
    logic signed [CW-1:0] move_x;
    logic signed [CW-1:0] move_y;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                    vertex_c_x, vertex_c_y, center_x, center_y, radius, move_x, move_y,
                    input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, center_x, center_y, radius, move_x, move_y,
                  output ready);
endinterface

>>> rtl/ctc_out_if.sv
`timescale 1ns / 1ps
interface ctc_out_if import ctc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 overlap;
    logic [1:0]           edge_index;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [CW-1:0] edge_distance;
    logic                 degenerate;

    modport source (output valid, overlap, edge_index, normal_x, normal_y,
                    edge_distance, degenerate, input ready);
    modport sink (input valid, overlap, edge_index, normal_x, normal_y,
                  edge_distance, degenerate, output ready);
endinterface

>>> rtl/circle_triangle_contact.sv
`timescale 1ns / 1ps
// channel  | dir | payload                                         | handshake
// i_in     | in  | vertices a b c, center, radius, move (Q16.16)  | valid/ready
// o_out    | out | overlap, edge_index, normal (Q2.14), distance  | valid/ready
//
// one item per cycle while the output register is not stalled; the delay is set by the
// 32-stage root pipeline and the 15-stage divider of each edge unit
// reset clears every valid bit; payload registers are not reset
// a stalled output register freezes the whole pipeline, so no item is lost
// or repeated; i_in.ready is high whenever the output register can move
`include "assert_macros.svh"
module circle_triangle_contact import ctc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctc_in_if.sink     i_in,
    ctc_out_if.source  o_out
);
    // global advance: output empty or being taken
    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    logic w_in_take;
    assign w_in_take = i_in.valid && w_en;

    // vertex table by fixed place, edge e runs from vertex e to vertex e+1
    logic signed [CW-1:0] w_vx [3];
    logic signed [CW-1:0] w_vy [3];
    assign w_vx[0] = i_in.vertex_a_x;
    assign w_vy[0] = i_in.vertex_a_y;
    assign w_vx[1] = i_in.vertex_b_x;
    assign w_vy[1] = i_in.vertex_b_y;
    assign w_vx[2] = i_in.vertex_c_x;
    assign w_vy[2] = i_in.vertex_c_y;

    logic      w_edge_v [3];
    t_edge_res w_edge_res [3];

    for (genvar e = 0; e < 3; e++) begin : g_edge
        localparam int J = (e + 1) % 3;
        ctc_edge u_edge (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_in_take),
            .i_p1_x  (w_vx[e]),
            .i_p1_y  (w_vy[e]),
            .i_p2_x  (w_vx[J]),
            .i_p2_y  (w_vy[J]),
            .i_c_x   (i_in.center_x),
            .i_c_y   (i_in.center_y),
            .i_m_x   (i_in.move_x),
            .i_m_y   (i_in.move_y),
            .o_valid (w_edge_v[e]),
            .o_res   (w_edge_res[e])
        );
    end

    // radius and moving flag ride alongside the edge units
    logic          r_dly_v   [EDGE_LAT];
    logic [CW-2:0] r_dly_rad [EDGE_LAT];
    logic          r_dly_mov [EDGE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < EDGE_LAT; i++) begin
                r_dly_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_dly_v[0] <= w_in_take;
            for (int i = 1; i < EDGE_LAT; i++) begin
                r_dly_v[i] <= r_dly_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_rad[0] <= i_in.radius;
            r_dly_mov[0] <= (i_in.move_x != '0) || (i_in.move_y != '0);
            for (int i = 1; i < EDGE_LAT; i++) begin
                r_dly_rad[i] <= r_dly_rad[i-1];
                r_dly_mov[i] <= r_dly_mov[i-1];
            end
        end
    end

    // t1: overlap test and distance magnitudes
    logic signed [DIST_W-1:0] w_rad;
    logic [DIST_W-1:0]        w_mag [3];
    logic                     w_ovl;
    logic                     w_degen;
    logic                     r_t1_v;
    t_edge_res                r_t1_res [3];
    logic [DIST_W-1:0]        r_t1_mag [3];
    logic                     r_t1_ovl;
    logic                     r_t1_mov;
    logic                     r_t1_degen;

    always_comb begin
        w_rad   = $signed({{(DIST_W-CW+1){1'b0}}, r_dly_rad[EDGE_LAT-1]});
        w_ovl   = 1'b1;
        w_degen = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_edge_res[i].sdist[DIST_W-1] ? DIST_W'(-w_edge_res[i].sdist)
                                                      : DIST_W'(w_edge_res[i].sdist);
            if (w_edge_res[i].sdist > w_rad) begin
                w_ovl = 1'b0;
            end
            w_degen = w_degen | w_edge_res[i].degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else if (w_en) begin
            r_t1_v <= r_dly_v[EDGE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t1_res[i] <= w_edge_res[i];
                r_t1_mag[i] <= w_mag[i];
            end
            r_t1_ovl   <= w_ovl;
            r_t1_mov   <= r_dly_mov[EDGE_LAT-1];
            r_t1_degen <= w_degen;
        end
    end

    // t2: removal edge choice, a-b first, then b-c, then c-a may take over
    logic                     w_take1, w_take2;
    logic [DIST_W-1:0]        w_mag01;
    logic [1:0]               w_best;
    t_edge_res                w_sel;
    logic signed [DIST_W-1:0] w_sat;

    always_comb begin
        w_take1 = r_t1_mov && r_t1_res[1].yield && (r_t1_mag[1] < r_t1_mag[0]);
        w_mag01 = w_take1 ? r_t1_mag[1] : r_t1_mag[0];
        w_take2 = r_t1_mov && r_t1_res[2].yield && (r_t1_mag[2] < w_mag01);
        if (w_take2) begin
            w_best = EDGE_CA;
            w_sel  = r_t1_res[2];
        end else if (w_take1) begin
            w_best = EDGE_BC;
            w_sel  = r_t1_res[1];
        end else begin
            w_best = EDGE_AB;
            w_sel  = r_t1_res[0];
        end
        // clamp to the coordinate range
        if (w_sel.sdist > SAT_MAX) begin
            w_sat = SAT_MAX;
        end else if (w_sel.sdist < SAT_MIN) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_sel.sdist;
        end
    end

    // output register
    logic                 r_out_ovl;
    logic [1:0]           r_out_edge;
    logic signed [NW-1:0] r_out_nx, r_out_ny;
    logic signed [CW-1:0] r_out_dist;
    logic                 r_out_degen;
    logic                 r_out_mov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_t1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_ovl   <= r_t1_ovl;
            r_out_edge  <= w_best;
            r_out_nx    <= w_sel.nx;
            r_out_ny    <= w_sel.ny;
            r_out_dist  <= w_sat[CW-1:0];
            r_out_degen <= r_t1_degen;
            r_out_mov   <= r_t1_mov;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.overlap       = r_out_ovl;
    assign o_out.edge_index    = r_out_edge;
    assign o_out.normal_x      = r_out_nx;
    assign o_out.normal_y      = r_out_ny;
    assign o_out.edge_distance = r_out_dist;
    assign o_out.degenerate    = r_out_degen;

    // edge units and the side delay line stay in step
    `ASSERT_IMPLIES(a_edge_sync, i_clk, i_rst_n, 1'b1, (w_edge_v[0] == r_dly_v[EDGE_LAT-1] && w_edge_v[1] == r_dly_v[EDGE_LAT-1] && w_edge_v[2] == r_dly_v[EDGE_LAT-1]))
    // a still move never leaves edge a-b
    `ASSERT_IMPLIES(a_still_keeps_ab, i_clk, i_rst_n, (r_out_valid && !r_out_mov), (r_out_edge == EDGE_AB))
    // unit normal stays within one in Q2.14
    `ASSERT_IMPLIES(a_normal_range, i_clk, i_rst_n, r_out_valid, (r_out_nx <= 16'sd16384 && r_out_nx >= -16'sd16384 && r_out_ny <= 16'sd16384 && r_out_ny >= -16'sd16384))
    // an empty output register never holds off the input
    `ASSERT_IMPLIES(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_in.ready)
    // a held result keeps its edge choice
    `ASSERT_NEXT(a_hold_edge, i_clk, i_rst_n, (r_out_valid && !o_out.ready), (r_out_edge == $past(r_out_edge)))
endmodule

>>> rtl/ctc_sqrt_pipe.sv
`timescale 1ns / 1ps
module ctc_sqrt_pipe import ctc_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_x,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [LEN_W-1:0]  o_root,
    output logic [SIDE_W-1:0] o_side
);
    // one root bit per stage, remainder kept as x - root^2
    logic [2*LEN_W-1:0] r_rem  [SQRT_STAGES];
    logic [LEN_W-1:0]   r_root [SQRT_STAGES];
    logic [SIDE_W-1:0]  r_side [SQRT_STAGES];
    logic               r_v    [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        localparam int K = SQRT_STAGES - 1 - g;
        logic [2*LEN_W-1:0] w_rem_in;
        logic [2*LEN_W-1:0] w_t;
        logic [2*LEN_W-1:0] n_rem;
        logic [LEN_W-1:0]   w_root_in;
        logic [LEN_W-1:0]   n_root;
        logic [SIDE_W-1:0]  w_side_in;
        logic               w_v_in;

        if (g == 0) begin : g_first
            assign w_rem_in  = (2*LEN_W)'(i_x);
            assign w_root_in = '0;
            assign w_side_in = i_side;
            assign w_v_in    = i_valid;
        end else begin : g_rest
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
            assign w_side_in = r_side[g-1];
            assign w_v_in    = r_v[g-1];
        end

        always_comb begin
            w_t = ((2*LEN_W)'(w_root_in) << (K + 1)) + ((2*LEN_W)'(1) << (2 * K));
            if (w_rem_in >= w_t) begin
                n_rem  = w_rem_in - w_t;
                n_root = w_root_in | (LEN_W'(1) << K);
            end else begin
                n_rem  = w_rem_in;
                n_root = w_root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];
endmodule

>>> rtl/ctc_div_pipe.sv
`timescale 1ns / 1ps
module ctc_div_pipe import ctc_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num_a,
    input  logic [NUM_W-1:0]  i_num_b,
    input  logic [LEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_q_a,
    output logic [Q_W-1:0]    o_q_b,
    output logic [SIDE_W-1:0] o_side
);
    // restoring division, two numerators over one divisor, one quotient bit a stage
    logic [NUM_W-1:0]  r_rem_a [DIV_STAGES];
    logic [NUM_W-1:0]  r_rem_b [DIV_STAGES];
    logic [Q_W-1:0]    r_q_a   [DIV_STAGES];
    logic [Q_W-1:0]    r_q_b   [DIV_STAGES];
    logic [LEN_W-1:0]  r_den   [DIV_STAGES];
    logic [SIDE_W-1:0] r_side  [DIV_STAGES];
    logic              r_v     [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        localparam int K = DIV_STAGES - 1 - g;
        logic [NUM_W-1:0]  w_ra, w_rb, w_t, n_ra, n_rb;
        logic [Q_W-1:0]    w_qa, w_qb, n_qa, n_qb;
        logic [LEN_W-1:0]  w_den;
        logic [SIDE_W-1:0] w_side;
        logic              w_v;

        if (g == 0) begin : g_first
            assign w_ra   = i_num_a;
            assign w_rb   = i_num_b;
            assign w_qa   = '0;
            assign w_qb   = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_rest
            assign w_ra   = r_rem_a[g-1];
            assign w_rb   = r_rem_b[g-1];
            assign w_qa   = r_q_a[g-1];
            assign w_qb   = r_q_b[g-1];
            assign w_den  = r_den[g-1];
            assign w_side = r_side[g-1];
            assign w_v    = r_v[g-1];
        end

        always_comb begin
            w_t  = NUM_W'(w_den) << K;
            n_ra = w_ra;
            n_qa = w_qa;
            n_rb = w_rb;
            n_qb = w_qb;
            if (w_ra >= w_t) begin
                n_ra = w_ra - w_t;
                n_qa = w_qa | (Q_W'(1) << K);
            end
            if (w_rb >= w_t) begin
                n_rb = w_rb - w_t;
                n_qb = w_qb | (Q_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a[g] <= n_ra;
                r_rem_b[g] <= n_rb;
                r_q_a[g]   <= n_qa;
                r_q_b[g]   <= n_qb;
                r_den[g]   <= w_den;
                r_side[g]  <= w_side;
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_q_a   = r_q_a[DIV_STAGES-1];
    assign o_q_b   = r_q_b[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
endmodule

>>> rtl/ctc_edge.sv
`timescale 1ns / 1ps
module ctc_edge import ctc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_p1_x,
    input  logic signed [CW-1:0] i_p1_y,
    input  logic signed [CW-1:0] i_p2_x,
    input  logic signed [CW-1:0] i_p2_y,
    input  logic signed [CW-1:0] i_c_x,
    input  logic signed [CW-1:0] i_c_y,
    input  logic signed [CW-1:0] i_m_x,
    input  logic signed [CW-1:0] i_m_y,
    output logic                 o_valid,
    output t_edge_res            o_res
);
    typedef struct packed {
        logic signed [OFS_W-1:0] ox;
        logic signed [OFS_W-1:0] oy;
        logic signed [CW-1:0]    mx;
        logic signed [CW-1:0]    my;
        logic                    sx;    // normal x negative
        logic                    sy;    // normal y negative
        logic                    zero;
    } t_div_side;

    typedef struct packed {
        logic [MW-1:0] a;
        logic [MW-1:0] b;
        t_div_side     ds;
    } t_sq_side;

    // stage 1: edge vector, magnitudes, center offset
    logic signed [OFS_W-1:0] w_ex, w_ey;
    logic [CW-1:0]           w_ax, w_ay;
    t_div_side               w_s1_side;
    logic [CW-1:0]           r_s1_ax, r_s1_ay;
    t_div_side               r_s1_side;
    logic                    r_s1_v;

    always_comb begin
        w_ex = OFS_W'(i_p1_x) - OFS_W'(i_p2_x);
        w_ey = OFS_W'(i_p1_y) - OFS_W'(i_p2_y);
        w_ax = w_ex[OFS_W-1] ? CW'(-w_ex) : CW'(w_ex);
        w_ay = w_ey[OFS_W-1] ? CW'(-w_ey) : CW'(w_ey);
        w_s1_side.ox   = OFS_W'(i_c_x) - OFS_W'(i_p2_x);
        w_s1_side.oy   = OFS_W'(i_c_y) - OFS_W'(i_p2_y);
        w_s1_side.mx   = i_m_x;
        w_s1_side.my   = i_m_y;
        w_s1_side.sx   = w_ey[OFS_W-1];
        w_s1_side.sy   = !w_ex[OFS_W-1] && (w_ex != '0);
        w_s1_side.zero = (w_ex == '0) && (w_ey == '0);
    end

    // stage 2: leading one of the larger magnitude
    logic [CW-1:0] w_m;
    logic [4:0]    w_shl;
    logic [CW-1:0] r_s2_ax, r_s2_ay;
    logic          r_s2_shr;
    logic [4:0]    r_s2_shl;
    t_div_side     r_s2_side;
    logic          r_s2_v;

    always_comb begin
        w_m   = (r_s1_ax > r_s1_ay) ? r_s1_ax : r_s1_ay;
        w_shl = '0;
        for (int i = 0; i < MW; i++) begin
            if (w_m[i]) begin
                w_shl = 5'(MW - 1 - i);
            end
        end
    end

    // stage 3: scale so the larger lies in [2^30, 2^31)
    logic [MW-1:0] r_s3_a, r_s3_b;
    t_div_side     r_s3_side;
    logic          r_s3_v;

    // stage 4 and 5: squares, then their sum
    logic [2*MW-1:0] r_s4_aa, r_s4_bb;
    logic [MW-1:0]   r_s4_a, r_s4_b;
    t_div_side       r_s4_side;
    logic            r_s4_v;
    logic [SQ_W-1:0] r_s5_sum;
    t_sq_side        r_s5_side;
    logic            r_s5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ax   <= w_ax;
            r_s1_ay   <= w_ay;
            r_s1_side <= w_s1_side;
            r_s2_ax   <= r_s1_ax;
            r_s2_ay   <= r_s1_ay;
            r_s2_shr  <= w_m[CW-1];
            r_s2_shl  <= w_shl;
            r_s2_side <= r_s1_side;
            r_s3_a    <= r_s2_shr ? MW'(r_s2_ax >> 1) : MW'(r_s2_ax << r_s2_shl);
            r_s3_b    <= r_s2_shr ? MW'(r_s2_ay >> 1) : MW'(r_s2_ay << r_s2_shl);
            r_s3_side <= r_s2_side;
            r_s4_aa   <= (2*MW)'(r_s3_a) * (2*MW)'(r_s3_a);
            r_s4_bb   <= (2*MW)'(r_s3_b) * (2*MW)'(r_s3_b);
            r_s4_a    <= r_s3_a;
            r_s4_b    <= r_s3_b;
            r_s4_side <= r_s3_side;
            r_s5_sum  <= SQ_W'(r_s4_aa) + SQ_W'(r_s4_bb);
            r_s5_side <= '{a: r_s4_a, b: r_s4_b, ds: r_s4_side};
        end
    end

    // edge length
    logic                   w_sq_v;
    logic [LEN_W-1:0]       w_len;
    logic [$bits(t_sq_side)-1:0] w_sq_side_bits;
    t_sq_side               w_sq_side;

    ctc_sqrt_pipe #(.SIDE_W($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_s5_v),
        .i_x     (r_s5_sum),
        .i_side  (r_s5_side),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side_bits)
    );
    assign w_sq_side = t_sq_side'(w_sq_side_bits);

    // rounded numerators for the normal components
    logic [NUM_W-1:0] r_p_na, r_p_nb;
    logic [LEN_W-1:0] r_p_len;
    t_div_side        r_p_side;
    logic             r_p_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_na   <= (NUM_W'(w_sq_side.a) << NF) + NUM_W'(w_len >> 1);
            r_p_nb   <= (NUM_W'(w_sq_side.b) << NF) + NUM_W'(w_len >> 1);
            r_p_len  <= w_len;
            r_p_side <= w_sq_side.ds;
        end
    end

    logic                         w_dv_v;
    logic [Q_W-1:0]               w_qa, w_qb;
    logic [$bits(t_div_side)-1:0] w_dv_side_bits;
    t_div_side                    w_dv_side;

    ctc_div_pipe #(.SIDE_W($bits(t_div_side))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_p_v),
        .i_num_a (r_p_na),
        .i_num_b (r_p_nb),
        .i_den   (r_p_len),
        .i_side  (r_p_side),
        .o_valid (w_dv_v),
        .o_q_a   (w_qa),
        .o_q_b   (w_qb),
        .o_side  (w_dv_side_bits)
    );
    assign w_dv_side = t_div_side'(w_dv_side_bits);

    // n1 signed normal, n2 products, n3 dot sums, n4 rounding to Q20.16
    logic signed [NW-1:0]     w_nx, w_ny;
    logic signed [NW-1:0]     r_n1_nx, r_n1_ny;
    t_div_side                r_n1_side;
    logic signed [PC_W-1:0]   r_n2_pcx, r_n2_pcy;
    logic signed [PM_W-1:0]   r_n2_pmx, r_n2_pmy;
    logic signed [NW-1:0]     r_n2_nx, r_n2_ny;
    logic                     r_n2_zero;
    logic signed [DS_W-1:0]   r_n3_dsum;
    logic signed [PM_W:0]     w_msum;
    logic                     r_n3_yield;
    logic signed [NW-1:0]     r_n3_nx, r_n3_ny;
    logic                     r_n3_zero;
    logic [DS_W-1:0]          w_dmag, w_rnd;
    logic signed [DIST_W-1:0] w_dist;
    t_edge_res                r_n4_res;
    logic                     r_n1_v, r_n2_v, r_n3_v, r_n4_v;

    always_comb begin
        w_nx = w_dv_side.sx ? -NW'(w_qb) : NW'(w_qb);
        w_ny = w_dv_side.sy ? -NW'(w_qa) : NW'(w_qa);
        if (w_dv_side.zero) begin
            w_nx = '0;
            w_ny = '0;
        end
        w_msum = (PM_W+1)'(r_n2_pmx) + (PM_W+1)'(r_n2_pmy);
        w_dmag = r_n3_dsum[DS_W-1] ? DS_W'(-r_n3_dsum) : DS_W'(r_n3_dsum);
        w_rnd  = (w_dmag + (DS_W'(1) << (NF - 1))) >> NF;
        w_dist = r_n3_dsum[DS_W-1] ? -DIST_W'(w_rnd) : DIST_W'(w_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_v <= 1'b0;
            r_n2_v <= 1'b0;
            r_n3_v <= 1'b0;
            r_n4_v <= 1'b0;
        end else if (i_en) begin
            r_n1_v <= w_dv_v;
            r_n2_v <= r_n1_v;
            r_n3_v <= r_n2_v;
            r_n4_v <= r_n3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1_nx        <= w_nx;
            r_n1_ny        <= w_ny;
            r_n1_side      <= w_dv_side;
            r_n2_pcx       <= PC_W'(r_n1_side.ox) * PC_W'(r_n1_nx);
            r_n2_pcy       <= PC_W'(r_n1_side.oy) * PC_W'(r_n1_ny);
            r_n2_pmx       <= PM_W'(r_n1_side.mx) * PM_W'(r_n1_nx);
            r_n2_pmy       <= PM_W'(r_n1_side.my) * PM_W'(r_n1_ny);
            r_n2_nx        <= r_n1_nx;
            r_n2_ny        <= r_n1_ny;
            r_n2_zero      <= r_n1_side.zero;
            r_n3_dsum      <= DS_W'(r_n2_pcx) + DS_W'(r_n2_pcy);
            r_n3_yield     <= w_msum[PM_W] || (w_msum == '0);
            r_n3_nx        <= r_n2_nx;
            r_n3_ny        <= r_n2_ny;
            r_n3_zero      <= r_n2_zero;
            r_n4_res.nx    <= r_n3_nx;
            r_n4_res.ny    <= r_n3_ny;
            r_n4_res.sdist <= w_dist;
            r_n4_res.degen <= r_n3_zero;
            r_n4_res.yield <= r_n3_yield;
        end
    end

    assign o_valid = r_n4_v;
    assign o_res   = r_n4_res;
endmodule
